>>> rtl/core/tlc_pkg.sv
// tlc_pkg: shared types and constants of the two-way traffic light controller
// used by tlc_cfg, tlc_step and two_way_traffic_light_controller; no dependencies
package tlc_pkg;

    // default phase durations in seconds and timer resolution
    localparam logic [7:0] RED_DEFAULT    = 8'd5;
    localparam logic [7:0] YELLOW_DEFAULT = 8'd2;
    localparam logic [7:0] GREEN_DEFAULT  = 8'd3;
    localparam int unsigned TICKS_PER_SECOND = 4;

    // derived widths
    localparam int unsigned QC_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int unsigned PT_W = $clog2(255 * TICKS_PER_SECOND + 1);

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_MAX_SECONDS     = 2'd0;
    localparam logic [1:0] CFG_MIN_SECONDS     = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_STEP = 2'd2;
    localparam logic [6:0] MAX_SECONDS_RESET     = 7'd99;
    localparam logic [6:0] MIN_SECONDS_RESET     = 7'd1;
    localparam logic [6:0] LONG_PRESS_STEP_RESET = 7'd10;

    // lamp bits
    localparam logic [2:0] LAMP_OFF = 3'b000;
    localparam logic [2:0] LAMP_RED = 3'b001;
    localparam logic [2:0] LAMP_YEL = 3'b010;
    localparam logic [2:0] LAMP_GRN = 3'b100;

    typedef enum logic [2:0] {
        MODE_RED_GREEN  = 3'd0,
        MODE_RED_YELLOW = 3'd1,
        MODE_GREEN_RED  = 3'd2,
        MODE_YELLOW_RED = 3'd3,
        MODE_EDIT_RED   = 3'd4,
        MODE_EDIT_YEL   = 3'd5,
        MODE_EDIT_GRN   = 3'd6
    } mode_t;

    typedef struct packed {
        logic [6:0] max_seconds;
        logic [6:0] min_seconds;
        logic [6:0] long_press_step;
    } tlc_cfg_t;

    typedef struct packed {
        logic quarter_tick;
        logic mode_press;
        logic inc_press;
        logic inc_long_press;
        logic save_press;
    } tlc_event_t;

    typedef struct packed {
        mode_t            mode;
        logic [7:0]       red_seconds;
        logic [7:0]       yellow_seconds;
        logic [7:0]       green_seconds;
        logic [7:0]       edit_value;
        logic [PT_W-1:0]  phase_ticks;
        logic [QC_W-1:0]  quarter_count;
        logic [7:0]       countdown_first;
        logic [7:0]       countdown_second;
        logic             blink_on;
    } tlc_state_t;

    typedef struct packed {
        logic [2:0] lamps_first_way;
        logic [2:0] lamps_second_way;
        logic [2:0] mode_now;
        logic [7:0] count_first;
        logic [7:0] count_second;
    } tlc_result_t;

endpackage

>>> rtl/core/tlc_cfg.sv
// tlc_cfg: configuration register file of the traffic light controller
// depends on tlc_pkg
module tlc_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_wdata,
    output tlc_pkg::tlc_cfg_t cfg
);
    import tlc_pkg::*;

    tlc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_seconds     <= MAX_SECONDS_RESET;
            cfg_reg.min_seconds     <= MIN_SECONDS_RESET;
            cfg_reg.long_press_step <= LONG_PRESS_STEP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_SECONDS:     cfg_reg.max_seconds     <= cfg_wdata;
                CFG_MIN_SECONDS:     cfg_reg.min_seconds     <= cfg_wdata;
                CFG_LONG_PRESS_STEP: cfg_reg.long_press_step <= cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/tlc_step.sv
// tlc_step: next-state and result logic for one polling step
// depends on tlc_pkg
module tlc_step (
    input  tlc_pkg::tlc_state_t  st,
    input  tlc_pkg::tlc_cfg_t    cfg,
    input  tlc_pkg::tlc_event_t  ev,
    output tlc_pkg::tlc_state_t  nxt,
    output tlc_pkg::tlc_result_t res
);
    import tlc_pkg::*;

    function automatic tlc_state_t enter_phase(tlc_state_t s, mode_t m);
        tlc_state_t r;
        r = s;
        r.mode          = m;
        r.phase_ticks   = '0;
        r.quarter_count = '0;
        case (m)
            MODE_RED_GREEN: begin
                r.countdown_first  = s.red_seconds;
                r.countdown_second = s.green_seconds;
            end
            MODE_RED_YELLOW: begin
                r.countdown_first  = s.red_seconds;
                r.countdown_second = s.yellow_seconds;
            end
            MODE_GREEN_RED: begin
                r.countdown_first  = s.green_seconds;
                r.countdown_second = s.red_seconds;
            end
            default: begin
                r.countdown_first  = s.yellow_seconds;
                r.countdown_second = s.red_seconds;
            end
        endcase
        return r;
    endfunction

    function automatic tlc_state_t enter_edit(tlc_state_t s, mode_t m);
        tlc_state_t r;
        r = s;
        r.mode     = m;
        r.blink_on = 1'b1;
        case (m)
            MODE_EDIT_RED: r.edit_value = s.red_seconds;
            MODE_EDIT_YEL: r.edit_value = s.yellow_seconds;
            default:       r.edit_value = s.green_seconds;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'hff : sum[7:0];
    endfunction

    logic [QC_W:0]   qc_inc;
    logic [7:0]      dur;
    logic [PT_W-1:0] limit;
    logic [PT_W:0]   pt_inc;
    logic            phase_end;
    mode_t           next_phase;
    logic [8:0]      edit_sum;
    logic [7:0]      edit_new;
    tlc_state_t      t;

    always_comb begin
        qc_inc   = {1'b0, st.quarter_count} + {{QC_W{1'b0}}, 1'b1};
        dur      = (st.mode == MODE_RED_GREEN || st.mode == MODE_GREEN_RED)
                   ? st.green_seconds : st.yellow_seconds;
        limit    = PT_W'(dur) * PT_W'(TICKS_PER_SECOND);
        pt_inc   = {1'b0, st.phase_ticks} + {{PT_W{1'b0}}, 1'b1};
        phase_end = ev.quarter_tick && (pt_inc >= {1'b0, limit});

        case (st.mode)
            MODE_RED_GREEN:  next_phase = MODE_RED_YELLOW;
            MODE_RED_YELLOW: next_phase = MODE_GREEN_RED;
            MODE_GREEN_RED:  next_phase = MODE_YELLOW_RED;
            default:         next_phase = MODE_RED_GREEN;
        endcase

        // edit arithmetic: increments then wrap past the maximum
        edit_sum = {1'b0, st.edit_value}
                 + {8'd0, ev.inc_press}
                 + (ev.inc_long_press ? {2'b00, cfg.long_press_step} : 9'd0);
        edit_new = (edit_sum > {2'b00, cfg.max_seconds})
                 ? {1'b0, cfg.min_seconds} : edit_sum[7:0];

        t = st;
        case (st.mode)
            MODE_RED_GREEN, MODE_RED_YELLOW, MODE_GREEN_RED, MODE_YELLOW_RED: begin
                if (ev.quarter_tick) begin
                    if (qc_inc >= (QC_W+1)'(TICKS_PER_SECOND)) begin
                        t.quarter_count = '0;
                        if (st.countdown_first != 8'd0)
                            t.countdown_first = st.countdown_first - 8'd1;
                        if (st.countdown_second != 8'd0)
                            t.countdown_second = st.countdown_second - 8'd1;
                    end else begin
                        t.quarter_count = qc_inc[QC_W-1:0];
                    end
                    if (!phase_end)
                        t.phase_ticks = pt_inc[PT_W-1:0];
                end
                // phase end wins over a mode press
                if (phase_end)
                    t = enter_phase(t, next_phase);
                else if (ev.mode_press)
                    t = enter_edit(t, MODE_EDIT_RED);
            end
            MODE_EDIT_RED, MODE_EDIT_YEL, MODE_EDIT_GRN: begin
                t.edit_value = edit_new;
                if (ev.quarter_tick)
                    t.blink_on = ~st.blink_on;
                if (ev.mode_press) begin
                    case (st.mode)
                        MODE_EDIT_RED: t = enter_edit(t, MODE_EDIT_YEL);
                        MODE_EDIT_YEL: t = enter_edit(t, MODE_EDIT_GRN);
                        default:       t = enter_phase(t, MODE_RED_GREEN);
                    endcase
                end else if (ev.save_press) begin
                    case (st.mode)
                        MODE_EDIT_RED: begin
                            // red must stay above yellow, green takes the rest
                            if (edit_new > st.yellow_seconds) begin
                                t.red_seconds   = edit_new;
                                t.green_seconds = edit_new - st.yellow_seconds;
                            end
                            t = enter_edit(t, MODE_EDIT_RED);
                        end
                        MODE_EDIT_YEL: begin
                            t.yellow_seconds = edit_new;
                            if (edit_new >= st.red_seconds)
                                t.red_seconds = sat_add(edit_new, st.green_seconds);
                            else
                                t.green_seconds = st.red_seconds - edit_new;
                            t = enter_edit(t, MODE_EDIT_YEL);
                        end
                        default: begin
                            t.green_seconds = edit_new;
                            t.red_seconds   = sat_add(edit_new, st.yellow_seconds);
                        end
                    endcase
                end
            end
            default: t = enter_phase(t, MODE_RED_GREEN);  // stray mode code
        endcase
        nxt = t;

        // result from the updated state
        res.mode_now = t.mode;
        case (t.mode)
            MODE_RED_GREEN: begin
                res.lamps_first_way  = LAMP_RED;
                res.lamps_second_way = LAMP_GRN;
            end
            MODE_RED_YELLOW: begin
                res.lamps_first_way  = LAMP_RED;
                res.lamps_second_way = LAMP_YEL;
            end
            MODE_GREEN_RED: begin
                res.lamps_first_way  = LAMP_GRN;
                res.lamps_second_way = LAMP_RED;
            end
            MODE_YELLOW_RED: begin
                res.lamps_first_way  = LAMP_YEL;
                res.lamps_second_way = LAMP_RED;
            end
            MODE_EDIT_RED: begin
                res.lamps_first_way  = t.blink_on ? LAMP_RED : LAMP_OFF;
                res.lamps_second_way = res.lamps_first_way;
            end
            MODE_EDIT_YEL: begin
                res.lamps_first_way  = t.blink_on ? LAMP_YEL : LAMP_OFF;
                res.lamps_second_way = res.lamps_first_way;
            end
            default: begin
                res.lamps_first_way  = t.blink_on ? LAMP_GRN : LAMP_OFF;
                res.lamps_second_way = res.lamps_first_way;
            end
        endcase
        if (t.mode == MODE_EDIT_RED || t.mode == MODE_EDIT_YEL || t.mode == MODE_EDIT_GRN) begin
            res.count_first  = t.edit_value;
            res.count_second = 8'd0;
        end else begin
            res.count_first  = t.countdown_first;
            res.count_second = t.countdown_second;
        end
    end

endmodule

>>> rtl/core/two_way_traffic_light_controller.sv
// two_way_traffic_light_controller: top level, stream ports, state and result registers
// depends on tlc_pkg, tlc_cfg and tlc_step
//
// Two-way traffic light controller driven by polling words. Each input word is one
// polling step: a 250 ms tick flag plus the button events. In auto mode the lights
// cycle red/green, red/yellow, green/red, yellow/red; each phase lasts
// TICKS_PER_SECOND ticks per second of its duration and both countdowns fall once a
// second. The mode button walks through red, yellow and green edit; increment, long
// press and save change and commit the durations, and the edited colour blinks on
// each tick. Every input word yields exactly one result word holding the lamps, the
// mode and the two display counts after the step. Rate: one word per clock cycle
// while the result register is read in time, with the result word on m_tdata in the
// cycle after input acceptance; the rate rests on the single state register that is
// updated by one pass of tlc_step per word. The result register frees the input side:
// a new word is taken whenever the result register is empty or being read in the same
// cycle. Configuration writes (max_seconds, min_seconds, long_press_step at index 0,
// 1, 2) are registered in tlc_cfg; index 3 is ignored and data keeps its low 7 bits.
module two_way_traffic_light_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // quarter_tick, mode_press, inc_press, inc_long_press,
                                   // save_press, zero pad [7:5]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // lamps_first_way[2:0], lamps_second_way[5:3],
                                   // mode_now[8:6], count_first[16:9],
                                   // count_second[24:17], zero pad [31:25]
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);
    import tlc_pkg::*;

    tlc_cfg_t    cfg;
    tlc_event_t  ev;
    tlc_state_t  state_reg;
    tlc_state_t  state_next;
    tlc_result_t res_next;
    tlc_result_t result_reg;
    logic        m_tvalid_reg;
    logic        accept;

    tlc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // unpack the polling word
    assign ev.quarter_tick   = s_tdata[0];
    assign ev.mode_press     = s_tdata[1];
    assign ev.inc_press      = s_tdata[2];
    assign ev.inc_long_press = s_tdata[3];
    assign ev.save_press     = s_tdata[4];

    tlc_step u_step (
        .st  (state_reg),
        .cfg (cfg),
        .ev  (ev),
        .nxt (state_next),
        .res (res_next)
    );

    // take a word when the result slot is free or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // controller state, updated once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode             <= MODE_RED_GREEN;
            state_reg.red_seconds      <= RED_DEFAULT;
            state_reg.yellow_seconds   <= YELLOW_DEFAULT;
            state_reg.green_seconds    <= GREEN_DEFAULT;
            state_reg.edit_value       <= 8'd0;
            state_reg.phase_ticks      <= '0;
            state_reg.quarter_count    <= '0;
            state_reg.countdown_first  <= RED_DEFAULT;
            state_reg.countdown_second <= GREEN_DEFAULT;
            state_reg.blink_on         <= 1'b1;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0,
                       result_reg.count_second,
                       result_reg.count_first,
                       result_reg.mode_now,
                       result_reg.lamps_second_way,
                       result_reg.lamps_first_way};

endmodule

>>> dv/tlc_scoreboard_pkg.sv
// tlc_scoreboard_pkg: polling word encodings and the result predictor / checker class
// for the two-way traffic light controller testbench; depends on tlc_pkg from the rtl
package tlc_scoreboard_pkg;
    import tlc_pkg::*;

    // polling word bits as they sit in s_tdata
    localparam logic [7:0] EV_NONE = 8'h00;
    localparam logic [7:0] EV_TICK = 8'h01;
    localparam logic [7:0] EV_MODE = 8'h02;
    localparam logic [7:0] EV_INC  = 8'h04;
    localparam logic [7:0] EV_LONG = 8'h08;
    localparam logic [7:0] EV_SAVE = 8'h10;
    localparam logic [7:0] EV_ALL  = EV_TICK | EV_MODE | EV_INC | EV_LONG | EV_SAVE;

    class tlc_scoreboard;
        tlc_cfg_t     regs;
        logic [2:0]   mode_code;
        logic [7:0]   red_s, yel_s, grn_s, edit_val;
        logic [7:0]   cnt_first, cnt_second;
        int unsigned  ticks_in_phase, quarters;
        logic         blink;
        tlc_result_t  lights_due_q[$];
        int           errors, words_noted, results_checked;
        int           phase_changes, edit_entries, saves;

        function new();
            regs.max_seconds     = MAX_SECONDS_RESET;
            regs.min_seconds     = MIN_SECONDS_RESET;
            regs.long_press_step = LONG_PRESS_STEP_RESET;
            mode_code      = MODE_RED_GREEN;
            red_s          = RED_DEFAULT;
            yel_s          = YELLOW_DEFAULT;
            grn_s          = GREEN_DEFAULT;
            edit_val       = 8'd0;
            cnt_first      = RED_DEFAULT;
            cnt_second     = GREEN_DEFAULT;
            ticks_in_phase = 0;
            quarters       = 0;
            blink          = 1'b1;
        endfunction

        function void write_register(logic [1:0] idx, logic [6:0] val);
            case (idx)
                CFG_MAX_SECONDS:     regs.max_seconds     = val;
                CFG_MIN_SECONDS:     regs.min_seconds     = val;
                CFG_LONG_PRESS_STEP: regs.long_press_step = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return lights_due_q.size();
        endfunction

        function logic [7:0] clip8(int unsigned v);
            return (v > 255) ? 8'd255 : 8'(v);
        endfunction

        function void load_phase(logic [2:0] m);
            mode_code      = m;
            ticks_in_phase = 0;
            quarters       = 0;
            case (m)
                MODE_RED_GREEN: begin
                    cnt_first = red_s;  cnt_second = grn_s;
                end
                MODE_RED_YELLOW: begin
                    cnt_first = red_s;  cnt_second = yel_s;
                end
                MODE_GREEN_RED: begin
                    cnt_first = grn_s;  cnt_second = red_s;
                end
                default: begin
                    cnt_first = yel_s;  cnt_second = red_s;
                end
            endcase
            phase_changes++;
        endfunction

        function void open_edit(logic [2:0] m);
            mode_code = m;
            blink     = 1'b1;
            if (m == MODE_EDIT_RED) edit_val = red_s;
            else if (m == MODE_EDIT_YEL) edit_val = yel_s;
            else edit_val = grn_s;
            edit_entries++;
        endfunction

        // one polling step: advance the light state and queue the result word it yields
        function void note_word(logic [7:0] w);
            logic        tick, mode_p, inc_p, long_p, save_p, phase_done;
            int unsigned dur, e;
            tlc_result_t r;
            tick   = (w & EV_TICK) != 0;
            mode_p = (w & EV_MODE) != 0;
            inc_p  = (w & EV_INC)  != 0;
            long_p = (w & EV_LONG) != 0;
            save_p = (w & EV_SAVE) != 0;
            phase_done = 1'b0;
            words_noted++;

            if (mode_code <= MODE_YELLOW_RED) begin
                if (tick) begin
                    dur = (mode_code == MODE_RED_GREEN || mode_code == MODE_GREEN_RED) ?
                          grn_s : yel_s;
                    quarters++;
                    if (quarters >= TICKS_PER_SECOND) begin
                        quarters = 0;
                        if (cnt_first != 0)  cnt_first  = cnt_first - 8'd1;
                        if (cnt_second != 0) cnt_second = cnt_second - 8'd1;
                    end
                    if (ticks_in_phase + 1 >= dur * TICKS_PER_SECOND) phase_done = 1'b1;
                    else ticks_in_phase++;
                end
                // phase end beats a mode press in the same step
                if (phase_done) load_phase((mode_code + 3'd1) & 3'd3);
                else if (mode_p) open_edit(MODE_EDIT_RED);
            end else if (mode_code <= MODE_EDIT_GRN) begin
                e = edit_val;
                if (inc_p) e += 1;
                if (long_p) e += regs.long_press_step;
                if (e > regs.max_seconds) e = regs.min_seconds;
                edit_val = 8'(e);
                if (tick) blink = ~blink;
                if (mode_p) begin
                    if (mode_code == MODE_EDIT_GRN) load_phase(MODE_RED_GREEN);
                    else open_edit(mode_code + 3'd1);
                end else if (save_p) begin
                    saves++;
                    if (mode_code == MODE_EDIT_RED) begin
                        if (edit_val > yel_s) begin
                            red_s = edit_val;
                            grn_s = red_s - yel_s;
                        end
                        open_edit(MODE_EDIT_RED);
                    end else if (mode_code == MODE_EDIT_YEL) begin
                        if (edit_val >= red_s) begin
                            red_s = clip8(edit_val + grn_s);
                            yel_s = edit_val;
                        end else begin
                            yel_s = edit_val;
                            grn_s = red_s - yel_s;
                        end
                        open_edit(MODE_EDIT_YEL);
                    end else begin
                        grn_s = edit_val;
                        red_s = clip8(grn_s + yel_s);
                    end
                end
            end else begin
                load_phase(MODE_RED_GREEN);
            end

            case (mode_code)
                MODE_RED_GREEN: begin
                    r.lamps_first_way = LAMP_RED;  r.lamps_second_way = LAMP_GRN;
                end
                MODE_RED_YELLOW: begin
                    r.lamps_first_way = LAMP_RED;  r.lamps_second_way = LAMP_YEL;
                end
                MODE_GREEN_RED: begin
                    r.lamps_first_way = LAMP_GRN;  r.lamps_second_way = LAMP_RED;
                end
                MODE_YELLOW_RED: begin
                    r.lamps_first_way = LAMP_YEL;  r.lamps_second_way = LAMP_RED;
                end
                MODE_EDIT_RED: begin
                    r.lamps_first_way = blink ? LAMP_RED : LAMP_OFF;
                    r.lamps_second_way = r.lamps_first_way;
                end
                MODE_EDIT_YEL: begin
                    r.lamps_first_way = blink ? LAMP_YEL : LAMP_OFF;
                    r.lamps_second_way = r.lamps_first_way;
                end
                default: begin
                    r.lamps_first_way = blink ? LAMP_GRN : LAMP_OFF;
                    r.lamps_second_way = r.lamps_first_way;
                end
            endcase
            r.mode_now = mode_code;
            if (mode_code <= MODE_YELLOW_RED) begin
                r.count_first  = cnt_first;
                r.count_second = cnt_second;
            end else begin
                r.count_first  = edit_val;
                r.count_second = 8'd0;
            end
            lights_due_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] data);
            tlc_result_t want;
            if (lights_due_q.size() == 0) begin
                $error("result word %h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = lights_due_q.pop_front();
            results_checked++;
            compare_field("lamps_first_way",  want.lamps_first_way,  data[2:0]);
            compare_field("lamps_second_way", want.lamps_second_way, data[5:3]);
            compare_field("mode_now",         want.mode_now,         data[8:6]);
            compare_field("count_first",      want.count_first,      data[16:9]);
            compare_field("count_second",     want.count_second,     data[24:17]);
        endfunction
    endclass

endpackage

>>> dv/two_way_traffic_light_controller_tb.sv
// two_way_traffic_light_controller_tb: stream-level test of the traffic light controller
// drives polling words and register writes, checks every result word against the
// scoreboard in tlc_scoreboard_pkg; depends on tlc_pkg and the rtl top level
module two_way_traffic_light_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;
    import tlc_scoreboard_pkg::*;

    // write to this index must leave every register untouched
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // register settings per test stretch: reset values first, then extremes and small
    // ranges that keep durations short and wrap edits often, and one random setting
    localparam int N_SETTINGS       = 8;
    localparam int RANDOM_SETTING   = 6;
    localparam int WORDS_PER_SETTING = 205;
    localparam logic [6:0] SET_MAX  [N_SETTINGS] = '{7'd99, 7'd127, 7'd1, 7'd6,
                                                     7'd1,  7'd9,   7'd0, 7'd12};
    localparam logic [6:0] SET_MIN  [N_SETTINGS] = '{7'd1,  7'd0,   7'd0, 7'd1,
                                                     7'd127, 7'd0,  7'd0, 7'd0};
    localparam logic [6:0] SET_STEP [N_SETTINGS] = '{7'd10, 7'd127, 7'd0, 7'd2,
                                                     7'd1,  7'd3,   7'd0, 7'd5};

    typedef enum int {RX_OPEN, RX_PERIODIC, RX_SPARSE, RX_COIN} rx_style_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // quarter_tick, mode_press, inc_press, inc_long_press,
                                    // save_press, zero pad [7:5]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // lamps_first_way, lamps_second_way, mode_now,
                                    // count_first, count_second, zero pad [31:25]
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [6:0]  cfg_wdata = 7'd0;

    tlc_scoreboard sb;

    // sender burst bookkeeping
    int burst_left = 0;
    bit sender_calm = 1'b0;
    int settings_used = 1;

    // receiver stall pattern
    rx_style_t rx_style = RX_OPEN;
    int rx_span = 0;
    int rx_period = 2;
    int rx_hold = 1;
    int rx_phase = 0;

    two_way_traffic_light_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // receiver: a new stall style after each random span, open stretches included
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_span   = $urandom_range(16, 96);
            rx_style  = rx_style_t'($urandom_range(0, 3));
            rx_period = $urandom_range(2, 9);
            rx_hold   = $urandom_range(1, rx_period - 1);
            rx_phase  = 0;
        end
        rx_span--;
        rx_phase = (rx_phase + 1) % rx_period;
        case (rx_style)
            RX_OPEN:     m_tready <= 1'b1;
            RX_PERIODIC: m_tready <= (rx_phase >= rx_hold);
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
            default:     m_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // result side: every accepted result word goes to the checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // hand one polling word over; starts and ends at a falling edge
    task automatic send_word(logic [7:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    // drop valid, let every expected result drain, then idle and return at a falling edge
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // back-to-back register writes, enable held high across them
    task automatic program_regs(logic [6:0] max_v, logic [6:0] min_v, logic [6:0] step_v,
                                bit poke_unused);
        logic [6:0] vals [3];
        logic [1:0] ids [3];
        logic [6:0] junk;
        vals = '{max_v, min_v, step_v};
        ids  = '{CFG_MAX_SECONDS, CFG_MIN_SECONDS, CFG_LONG_PRESS_STEP};
        junk = 7'($urandom());
        for (int i = 0; i < 3; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= ids[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.write_register(ids[i], vals[i]);
            @(negedge aclk);
        end
        if (poke_unused) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_UNUSED_INDEX;
            cfg_wdata <= junk;
            @(posedge aclk);
            sb.write_register(CFG_UNUSED_INDEX, junk);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // walk the whole story once with reset registers and default durations
    task automatic run_directed();
        send_word(EV_NONE);                             // all fields low
        send_word(EV_TICK | EV_INC | EV_LONG | EV_SAVE); // buttons ignored in auto
        repeat (10) send_word(EV_TICK);                 // up to one tick before phase end
        send_word(EV_ALL);        // phase end wins over the mode press
        send_word(EV_MODE);       // into red edit, value loaded from red
        send_word(EV_INC | EV_LONG);
        send_word(EV_SAVE);       // red above yellow is kept, green follows
        send_word(EV_TICK | EV_MODE);  // blink toggle, then yellow edit
        send_word(EV_INC | EV_LONG);
        send_word(EV_LONG);
        send_word(EV_SAVE);       // yellow at or above red grows red
        send_word(EV_INC | EV_SAVE);   // yellow below red shrinks green
        send_word(EV_MODE);       // green edit
        send_word(EV_TICK | EV_INC);
        send_word(EV_SAVE);       // green save, stays in green edit
        send_word(EV_MODE);       // back to auto with a full reload
    endtask

    function automatic logic [7:0] random_edit_word();
        logic [7:0] w;
        w = EV_NONE;
        if ($urandom_range(0, 1) == 0) w |= EV_TICK;
        if ($urandom_range(0, 1) == 0) w |= EV_INC;
        if ($urandom_range(0, 2) == 0) w |= EV_LONG;
        if ($urandom_range(0, 9) == 0) w |= EV_SAVE;
        return w;
    endfunction

    // well-formed edit pass: enter, tweak, maybe save, step through the colours
    task automatic edit_session();
        logic [7:0] w;
        if (sb.mode_code <= MODE_YELLOW_RED) begin
            w = EV_MODE;
            // now and then the press may land on a phase end and be dropped
            if ($urandom_range(0, 3) == 0) w |= EV_TICK;
            send_word(w);
        end
        while (sb.mode_code >= MODE_EDIT_RED && sb.mode_code <= MODE_EDIT_GRN) begin
            repeat ($urandom_range(0, 5)) send_word(random_edit_word());
            if ($urandom_range(0, 2) != 0)
                send_word(EV_SAVE | (random_edit_word() & (EV_TICK | EV_INC | EV_LONG)));
            if ($urandom_range(0, 3) != 0)
                send_word(EV_MODE | (8'($urandom()) & (EV_TICK | EV_INC | EV_LONG | EV_SAVE)));
        end
    endtask

    // mostly ticks so phases run out; stray buttons other than mode now and then
    task automatic auto_run(int n);
        logic [7:0] w;
        repeat (n) begin
            w = ($urandom_range(0, 7) != 0) ? EV_TICK : EV_NONE;
            if ($urandom_range(0, 7) == 0) w |= (EV_INC | EV_LONG | EV_SAVE) & 8'($urandom());
            send_word(w);
        end
    endtask

    task automatic run_random(int n);
        int target;
        int pick;
        int left;
        int len;
        target = sb.words_noted + n;
        while (sb.words_noted < target) begin
            pick = $urandom_range(0, 99);
            left = target - sb.words_noted;
            if (pick < 45) edit_session();
            else if (pick < 85) begin
                // long tick runs stop at the end of the stretch
                len = $urandom_range(4, 120);
                auto_run((len < left) ? len : left);
            end
            else repeat ($urandom_range(1, 10)) send_word(8'($urandom_range(0, 31)));
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        for (int p = 0; p < N_SETTINGS; p++) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if (p > 0) begin
                settle();
                if (p == RANDOM_SETTING)
                    program_regs(7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)),
                                 7'($urandom_range(0, 127)), 1'b0);
                else
                    program_regs(SET_MAX[p], SET_MIN[p], SET_STEP[p], p == 5);
                settings_used++;
            end
            run_random(WORDS_PER_SETTING);
        end
        settle();

        $display("covered %0d polling words under %0d register settings, %0d results checked",
                 sb.words_noted, settings_used, sb.results_checked);
        $display("saw %0d phase loads, %0d edit entries, %0d saves, %0d mismatches",
                 sb.phase_changes, sb.edit_entries, sb.saves, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #400000;
        $error("run did not finish in time, %0d results still expected", sb.pending());
        $display("FAIL");
        $finish;
    end

endmodule
